### rtl/sensor_frame_parser_with_timeout_top_assert.svh
// Assertion macros for the sensor frame parser.
// Used only by sensor_frame_parser_with_timeout_top; expects clk and rst in scope.
`ifndef SENSOR_FRAME_PARSER_WITH_TIMEOUT_TOP_ASSERT_SVH
`define SENSOR_FRAME_PARSER_WITH_TIMEOUT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFPT_ASSERT_IMPL(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("sfpt: same-cycle check failed");

// next-cycle implication, checked outside reset
`define SFPT_ASSERT_NEXT(label, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("sfpt: next-cycle check failed");

`endif

### rtl/sfpt_pkg.sv
// Shared types and constants for the sensor frame parser.
// No dependencies.
`default_nettype none

package sfpt_pkg;

  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int ADDR_W          = 5;
  localparam int DATA_W          = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_HEADER_FIRST  = 3'd0;
  localparam logic [2:0] REG_HEADER_SECOND = 3'd1;
  localparam logic [2:0] REG_LINE_TYPE     = 3'd2;
  localparam logic [2:0] REG_QR_TYPE       = 3'd3;
  localparam logic [2:0] REG_LINE_TIMEOUT  = 3'd4;
  localparam logic [2:0] REG_QR_TIMEOUT    = 3'd5;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'd85;
  localparam logic [7:0]  LINE_TYPE_RST     = 8'd1;
  localparam logic [7:0]  QR_TYPE_RST       = 8'd2;
  localparam logic [15:0] TIMEOUT_RST       = 16'd500;

  localparam logic [7:0]  LINE_LEN = 8'd2;
  localparam logic [7:0]  QR_LEN   = 8'd4;
  localparam logic [15:0] AGE_MAX  = 16'hFFFF;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_LINE    = 3'd1;
  localparam logic [2:0] EV_QR      = 3'd2;
  localparam logic [2:0] EV_BADSUM  = 3'd3;
  localparam logic [2:0] EV_TOOLONG = 3'd4;
  localparam logic [2:0] EV_IGNORED = 3'd5;

  localparam logic CMD_BYTE = 1'b0;

  typedef enum logic [5:0] {
    PH_HEAD1   = 6'b000001,
    PH_HEAD2   = 6'b000010,
    PH_TYPE    = 6'b000100,
    PH_LEN     = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_SUM     = 6'b100000
  } phase_t;

  typedef struct packed {
    logic signed [15:0] line_pos;
    logic               line_ok;
    logic signed [15:0] qr_x;
    logic signed [15:0] qr_y;
    logic               qr_ok;
    logic [2:0]         frame_event;
  } res_t;

endpackage

`default_nettype wire

### rtl/sensor_frame_parser_with_timeout_top.sv
// Sensor frame parser with freshness timeout: byte framing, checksum, age counters.
// Depends on sfpt_pkg and sensor_frame_parser_with_timeout_top_assert.svh.
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, command, rx_byte      | one byte or one tick
//  out     | out_valid, out_ready, line_pos .. event   | one status result per in beat
//  cfg     | psel, penable, pwrite, paddr, pwdata, ... | APB register access
//
// One beat per cycle while in_ready is high; each result is registered.
// All parsing and age logic sits between the state registers and the result register.
// A skid register behind the result register keeps in_ready high while one result
// waits; in_ready drops only when both are full.
// rst is synchronous; after it the block takes beats at once (no clearing pass).
`default_nettype none

module sensor_frame_parser_with_timeout_top
  import sfpt_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              command,
  input  wire logic [7:0]        rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     line_pos,
  output logic                   line_ok,
  output logic signed [15:0]     qr_x,
  output logic signed [15:0]     qr_y,
  output logic                   qr_ok,
  output logic [2:0]             frame_event,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  // configuration
  logic [7:0]  header_first, header_second, line_type_code, qr_type_code;
  logic [15:0] line_timeout_ticks, qr_timeout_ticks;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first       <= HEADER_FIRST_RST;
      header_second      <= HEADER_SECOND_RST;
      line_type_code     <= LINE_TYPE_RST;
      qr_type_code       <= QR_TYPE_RST;
      line_timeout_ticks <= TIMEOUT_RST;
      qr_timeout_ticks   <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_HEADER_FIRST:  header_first       <= pwdata[7:0];
        REG_HEADER_SECOND: header_second      <= pwdata[7:0];
        REG_LINE_TYPE:     line_type_code     <= pwdata[7:0];
        REG_QR_TYPE:       qr_type_code       <= pwdata[7:0];
        REG_LINE_TIMEOUT:  line_timeout_ticks <= pwdata[15:0];
        REG_QR_TIMEOUT:    qr_timeout_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_HEADER_FIRST:  prdata = {24'd0, header_first};
      REG_HEADER_SECOND: prdata = {24'd0, header_second};
      REG_LINE_TYPE:     prdata = {24'd0, line_type_code};
      REG_QR_TYPE:       prdata = {24'd0, qr_type_code};
      REG_LINE_TIMEOUT:  prdata = {16'd0, line_timeout_ticks};
      REG_QR_TIMEOUT:    prdata = {16'd0, qr_timeout_ticks};
      default:           prdata = '0;
    endcase
  end

  // parser and channel state
  phase_t      phase, phase_next;
  logic [7:0]  frame_kind, frame_kind_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  payload_index, payload_index_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] line_value, line_value_next;
  logic [15:0] qr_x_value, qr_x_value_next;
  logic [15:0] qr_y_value, qr_y_value_next;
  logic        line_fresh, line_fresh_next;
  logic        qr_fresh, qr_fresh_next;
  logic [15:0] line_age, line_age_next;
  logic [15:0] qr_age, qr_age_next;
  logic [2:0]  event_next;

  // only the first four payload bytes are ever interpreted
  logic [7:0]  pay [4];
  logic        pay_wr;

  logic        acc;
  logic        out_pop;
  logic        skid_valid;
  res_t        out_res, skid_res, new_res;

  assign acc     = in_valid && in_ready;
  assign out_pop = out_valid && out_ready;

  always_comb begin
    logic [15:0] la_inc, qa_inc;
    logic [7:0]  idx_inc;
    la_inc  = (line_age == AGE_MAX) ? line_age : line_age + 16'd1;
    qa_inc  = (qr_age == AGE_MAX) ? qr_age : qr_age + 16'd1;
    idx_inc = payload_index + 8'd1;

    phase_next         = phase;
    frame_kind_next    = frame_kind;
    frame_length_next  = frame_length;
    payload_index_next = payload_index;
    running_sum_next   = running_sum;
    line_value_next    = line_value;
    qr_x_value_next    = qr_x_value;
    qr_y_value_next    = qr_y_value;
    line_fresh_next    = line_fresh;
    qr_fresh_next      = qr_fresh;
    line_age_next      = line_age;
    qr_age_next        = qr_age;
    event_next         = EV_NONE;
    pay_wr             = 1'b0;

    if (command != CMD_BYTE) begin
      line_age_next = la_inc;
      qr_age_next   = qa_inc;
      if (line_fresh && (la_inc > line_timeout_ticks)) line_fresh_next = 1'b0;
      if (qr_fresh && (qa_inc > qr_timeout_ticks))     qr_fresh_next   = 1'b0;
    end else begin
      case (phase)
        PH_HEAD1: begin
          if (rx_byte == header_first) phase_next = PH_HEAD2;
        end
        PH_HEAD2: begin
          // second header wins when both header values are equal
          if (rx_byte == header_second)     phase_next = PH_TYPE;
          else if (rx_byte == header_first) phase_next = PH_HEAD2;
          else                              phase_next = PH_HEAD1;
        end
        PH_TYPE: begin
          frame_kind_next  = rx_byte;
          running_sum_next = rx_byte;
          phase_next       = PH_LEN;
        end
        PH_LEN: begin
          frame_length_next  = rx_byte;
          running_sum_next   = running_sum + rx_byte;
          payload_index_next = 8'd0;
          if (rx_byte > MaxLen) begin
            event_next        = EV_TOOLONG;
            phase_next        = PH_HEAD1;
            frame_kind_next   = 8'd0;
            frame_length_next = 8'd0;
            running_sum_next  = 8'd0;
          end else if (rx_byte == 8'd0) begin
            phase_next = PH_SUM;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          pay_wr             = (payload_index < QR_LEN);
          payload_index_next = idx_inc;
          running_sum_next   = running_sum + rx_byte;
          if (idx_inc >= frame_length) phase_next = PH_SUM;
        end
        PH_SUM: begin
          if (rx_byte != running_sum) begin
            event_next = EV_BADSUM;
          end else if (frame_kind == line_type_code && frame_length == LINE_LEN) begin
            event_next      = EV_LINE;
            line_value_next = {pay[1], pay[0]};
            line_fresh_next = 1'b1;
            line_age_next   = 16'd0;
          end else if (frame_kind == qr_type_code && frame_length == QR_LEN) begin
            event_next      = EV_QR;
            qr_x_value_next = {pay[1], pay[0]};
            qr_y_value_next = {pay[3], pay[2]};
            qr_fresh_next   = 1'b1;
            qr_age_next     = 16'd0;
          end else begin
            event_next = EV_IGNORED;
          end
          phase_next         = PH_HEAD1;
          frame_kind_next    = 8'd0;
          frame_length_next  = 8'd0;
          payload_index_next = 8'd0;
          running_sum_next   = 8'd0;
        end
        default: begin
          phase_next         = PH_HEAD1;
          frame_kind_next    = 8'd0;
          frame_length_next  = 8'd0;
          payload_index_next = 8'd0;
          running_sum_next   = 8'd0;
        end
      endcase
    end

    new_res.line_pos    = line_value_next;
    new_res.line_ok     = line_fresh_next;
    new_res.qr_x        = qr_x_value_next;
    new_res.qr_y        = qr_y_value_next;
    new_res.qr_ok       = qr_fresh_next;
    new_res.frame_event = event_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEAD1;
      frame_kind    <= 8'd0;
      frame_length  <= 8'd0;
      payload_index <= 8'd0;
      running_sum   <= 8'd0;
      line_value    <= 16'd0;
      qr_x_value    <= 16'd0;
      qr_y_value    <= 16'd0;
      line_fresh    <= 1'b0;
      qr_fresh      <= 1'b0;
      line_age      <= 16'd0;
      qr_age        <= 16'd0;
    end else if (acc) begin
      phase         <= phase_next;
      frame_kind    <= frame_kind_next;
      frame_length  <= frame_length_next;
      payload_index <= payload_index_next;
      running_sum   <= running_sum_next;
      line_value    <= line_value_next;
      qr_x_value    <= qr_x_value_next;
      qr_y_value    <= qr_y_value_next;
      line_fresh    <= line_fresh_next;
      qr_fresh      <= qr_fresh_next;
      line_age      <= line_age_next;
      qr_age        <= qr_age_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && pay_wr) pay[payload_index[1:0]] <= rx_byte;
  end

  // result register plus skid register
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= acc;
      end
    end else if (acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_pop) begin
      if (skid_valid) out_res <= skid_res;
      else if (acc)   out_res <= new_res;
    end else if (acc) begin
      skid_res <= new_res;
    end
  end

  assign line_pos    = out_res.line_pos;
  assign line_ok     = out_res.line_ok;
  assign qr_x        = out_res.qr_x;
  assign qr_y        = out_res.qr_y;
  assign qr_ok       = out_res.qr_ok;
  assign frame_event = out_res.frame_event;

`include "sensor_frame_parser_with_timeout_top_assert.svh"

  `SFPT_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid)
  `SFPT_ASSERT_IMPL(a_line_ev_fresh, out_valid && frame_event == EV_LINE, line_ok)
  `SFPT_ASSERT_IMPL(a_qr_ev_fresh, out_valid && frame_event == EV_QR, qr_ok)
  `SFPT_ASSERT_NEXT(a_beat_gives_result, acc, out_valid)

endmodule

`default_nettype wire
